// ----- rtl/mbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the Mandelbrot escape-time pixel core.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 36;

  localparam logic [CFG_AW-1:0] CFG_X_ORIGIN   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_Y_TOP      = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_STEP_SIZE  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MAX_ITER   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_ESC_LIMIT  = 3'd4;

  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_PALETTE = 1'b1;

  localparam int COORD_W = 12;
  localparam int COUNT_W = 16;
  localparam int COLOR_W = 32;
  localparam int FRAC_W  = 28;

  typedef struct packed {
    logic load_px;
    logic coord_mul;
    logic coord_add;
    logic update;
    logic mult;
    logic step;
    logic pal_wr;
    logic pal_rd;
    logic out_load;
  } mbe_cmd_t;

  typedef struct packed {
    logic px_ok;
    logic keep_going;
    logic under;
  } mbe_status_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] res;
    if ((v[47:31] != '0) && (v[47:31] != '1)) begin
      res = v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/mbe_palette.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_palette
// Palette color memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mbe_palette
  import mbe_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int PAL_AW        = 8
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [7:0]         wr_slot,
  input  logic [COLOR_W-1:0] wr_color,
  input  logic               rd_en,
  input  logic [PAL_AW-1:0]  rd_idx,
  output logic [COLOR_W-1:0] rd_data
);

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rd_data_r;
  logic [PAL_AW+7:0]  slot_ext;
  logic               slot_ok;

  assign slot_ext = {{PAL_AW{1'b0}}, wr_slot};
  assign slot_ok  = slot_ext < (PAL_AW+8)'(PALETTE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en && slot_ok) begin
      mem[slot_ext[PAL_AW-1:0]] <= wr_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/mbe_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_datapath
// Coordinate mapping and the z = z*z + c iteration in Q4.28 fixed point.
// ----------------------------------------------------------------------------
module mbe_datapath
  import mbe_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int PAL_AW        = 8,
  parameter int MAX_COORD     = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mbe_cmd_t            cmd,
  input  logic [COORD_W-1:0]  in_col,
  input  logic [COORD_W-1:0]  in_row,
  input  logic signed [31:0]  x_origin,
  input  logic signed [31:0]  y_top,
  input  logic [30:0]         step_size,
  input  logic [COUNT_W-1:0]  max_iter,
  input  logic [35:0]         esc_limit,
  output mbe_status_t         status,
  output logic [COUNT_W-1:0]  count,
  output logic [PAL_AW-1:0]   pal_idx
);

  logic [COORD_W-1:0]  col_r, row_r;
  logic [42:0]         pcx_r, pcy_r;
  logic signed [31:0]  cx_r, cy_r;
  logic signed [31:0]  zx_r, zy_r;
  logic signed [63:0]  pxx_r, pyy_r, pxy_r;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [PAL_AW-1:0]   pidx_r, pidx_nxt;

  logic signed [47:0]  sum_x, sum_y, nx_w, ny_w;
  logic [63:0]         mag;
  logic [63:0]         limit;
  logic                bounded;

  assign sum_x = 48'(x_origin) + {5'd0, pcx_r};
  assign sum_y = 48'(y_top) - {5'd0, pcy_r};
  assign nx_w  = 48'(pxx_r >>> FRAC_W) - 48'(pyy_r >>> FRAC_W) + 48'(cx_r);
  assign ny_w  = 48'(pxy_r >>> (FRAC_W - 1)) + 48'(cy_r);

  assign mag     = $unsigned(pxx_r) + $unsigned(pyy_r);
  assign limit   = {esc_limit, {FRAC_W{1'b0}}};
  assign bounded = mag < limit;

  assign status.px_ok      = ({5'd0, in_col} < 17'(MAX_COORD)) &&
                             ({5'd0, in_row} < 17'(MAX_COORD));
  assign status.under      = count_r < max_iter;
  assign status.keep_going = bounded && status.under;

  assign count_nxt = count_r + 1'b1;
  assign pidx_nxt  = (pidx_r == PAL_AW'(PALETTE_DEPTH - 1)) ? '0 : pidx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      col_r <= in_col;
      row_r <= in_row;
    end
    if (cmd.coord_mul) begin
      pcx_r <= col_r * step_size;
      pcy_r <= row_r * step_size;
    end
    if (cmd.coord_add) begin
      cx_r  <= sat32(sum_x);
      cy_r  <= sat32(sum_y);
      pxx_r <= '0;
      pyy_r <= '0;
      pxy_r <= '0;
    end else if (cmd.mult) begin
      pxx_r <= zx_r * zx_r;
      pyy_r <= zy_r * zy_r;
      pxy_r <= zx_r * zy_r;
    end
    if (cmd.update) begin
      zx_r <= sat32(nx_w);
      zy_r <= sat32(ny_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pidx_r  <= '0;
    end else if (cmd.coord_add) begin
      count_r <= '0;
      pidx_r  <= '0;
    end else if (cmd.step) begin
      count_r <= count_nxt;
      pidx_r  <= pidx_nxt;
    end
  end

  assign count   = count_r;
  assign pal_idx = pidx_r;

endmodule

// ----- rtl/mbe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer that steps the datapath through one pixel or palette word.
// ----------------------------------------------------------------------------
module mbe_ctrl
  import mbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_kind,
  input  mbe_status_t status,
  input  logic        out_busy,
  output logic        in_ready,
  output mbe_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMUL = 3'd1;
  localparam logic [2:0] S_CADD = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_PALETTE) begin
            cmd.pal_wr = 1'b1;
          end else if (status.px_ok) begin
            cmd.load_px = 1'b1;
            state_nxt   = S_CMUL;
          end
        end
      end
      S_CMUL: begin
        cmd.coord_mul = 1'b1;
        state_nxt     = S_CADD;
      end
      S_CADD: begin
        cmd.coord_add = 1'b1;
        state_nxt     = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mult  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (status.keep_going) begin
          cmd.step  = 1'b1;
          state_nxt = S_UPD;
        end else begin
          cmd.pal_rd = status.under;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/mandelbrot_escape_time_pixel_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core
// Escape-time Mandelbrot pixel engine with a palette lookup, Q4.28 fixed point.
// ----------------------------------------------------------------------------
// Channel  Direction  Word
// in_      slave      tdata: column, row, palette_slot, palette_color; tuser: kind
// out_     master     tdata: pixel_color, iteration_count
// cfg_     slave      cfg_addr register index, cfg_data value
//
// A pixel runs the coordinate multiply and add states, then passes through the
// update, square and check states until it escapes or reaches the limit.
// A palette word, or a pixel outside the frame, is taken in the idle state.
// Reset is synchronous; it clears the configuration and the sequencer.
// A finished result waits in the output register while the next word is
// taken; a pixel stalls in its last cycle until that register is free.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core
  import mbe_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_COORD     = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // column, row, palette_slot, palette_color
  input  logic              in_tuser,   // kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // pixel_color, iteration_count
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int PalAw = $clog2(PALETTE_DEPTH);

  logic signed [31:0]  x_origin_r, y_top_r;
  logic [30:0]         step_size_r;
  logic [COUNT_W-1:0]  max_iter_r;
  logic [35:0]         esc_limit_r;

  logic                out_valid_r;
  logic [COLOR_W-1:0]  out_color_r;
  logic [COUNT_W-1:0]  out_count_r;

  mbe_cmd_t            cmd;
  mbe_status_t         status;
  logic [COUNT_W-1:0]  count;
  logic [PalAw-1:0]    pal_idx;
  logic [COLOR_W-1:0]  pal_data;
  logic                out_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r  <= '0;
      y_top_r     <= '0;
      step_size_r <= '0;
      max_iter_r  <= '0;
      esc_limit_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_X_ORIGIN:  x_origin_r  <= cfg_data[31:0];
        CFG_Y_TOP:     y_top_r     <= cfg_data[31:0];
        CFG_STEP_SIZE: step_size_r <= cfg_data[30:0];
        CFG_MAX_ITER:  max_iter_r  <= cfg_data[15:0];
        CFG_ESC_LIMIT: esc_limit_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_busy = out_valid_r && !out_tready;

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .status   (status),
    .out_busy (out_busy),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  mbe_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .PAL_AW        (PalAw),
    .MAX_COORD     (MAX_COORD)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_col    (in_tdata[11:0]),
    .in_row    (in_tdata[23:12]),
    .x_origin  (x_origin_r),
    .y_top     (y_top_r),
    .step_size (step_size_r),
    .max_iter  (max_iter_r),
    .esc_limit (esc_limit_r),
    .status    (status),
    .count     (count),
    .pal_idx   (pal_idx)
  );

  mbe_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .PAL_AW        (PalAw)
  ) u_palette (
    .clk      (clk),
    .wr_en    (cmd.pal_wr),
    .wr_slot  (in_tdata[31:24]),
    .wr_color (in_tdata[63:32]),
    .rd_en    (cmd.pal_rd),
    .rd_idx   (pal_idx),
    .rd_data  (pal_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_color_r <= status.under ? pal_data : '0;
      out_count_r <= count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_color_r};

  a_count_in_limit : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[47:32] <= max_iter_r))
    else $error("iteration count above the iteration limit");

  a_load_when_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_pixel_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == KIND_PIXEL) && status.px_ok) |=> !in_tready)
    else $error("input taken while a pixel is in progress");

endmodule

// ----- tb/mandelbrot_escape_time_pixel_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core_test
// Self-checking testbench for the Mandelbrot escape-time pixel core. A short
// table of directed words and register writes exercises reset values, the
// coordinate and register extremes, saturation and the escape boundary. Then
// randomized pixel and palette words follow, under varying viewports and
// iteration limits and with random idling on both streams. Every result word
// is compared with the table's expected value or with a fixed-point
// escape-time predictor kept in step with the register and palette writes.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core_test;
  import mbe_pkg::*;

  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          ITEMS_PER_SETTING = 120;
  localparam logic [35:0] ESC_FOUR = 36'h0_4000_0000;

  typedef enum logic [1:0] {ROW_REG, ROW_WORD, ROW_TYPED} row_op_t;

  typedef struct packed {
    row_op_t           op;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] val;
    logic              kind;
    logic [11:0]       col;
    logic [11:0]       row;
    logic [7:0]        slot;
    logic [31:0]       color;
    logic [31:0]       want_color;
    logic [15:0]       want_count;
  } vec_row_t;

  typedef struct packed {
    logic [31:0] color;
    logic [15:0] count;
  } pixel_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [63:0]       in_tdata;   // column, row, palette_slot, palette_color
  logic              in_tuser;   // kind
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;  // pixel_color, iteration_count
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_data;

  mandelbrot_escape_time_pixel_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // Shadow of the block's registers and palette.
  longint      cur_x_origin;
  longint      cur_y_top;
  longint      cur_step;
  int unsigned cur_max_iter;
  logic [35:0] cur_esc_limit;
  logic [31:0] palette_shadow [256];
  bit          palette_loaded [256];

  pixel_result_t pix_expect_q [$];
  vec_row_t      dir_table [$];

  int          src_idle_pct;
  int          sink_stall_pct;
  logic        hold_req;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;
  int          mismatch_count;
  int          pixel_words;
  int          palette_words;
  int          reg_writes;
  int          settings;
  int          inside_count;
  int          deepest;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_q428(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Escape-time iteration in Q4.28; escaped is low when the count limit ended it.
  task automatic run_escape(input logic [11:0] col, input logic [11:0] row,
                            output logic [15:0] n, output bit escaped);
    longint      cx, cy, zx, zy, xx, yy, t;
    logic [63:0] mag, lim;
    int unsigned cnt;
    bit          in_bound;
    cx = clamp_q428(cur_x_origin + longint'(col) * cur_step);
    cy = clamp_q428(cur_y_top - longint'(row) * cur_step);
    lim = 64'(cur_esc_limit) << 28;
    zx = 0;
    zy = 0;
    cnt = 0;
    while (1) begin
      xx = (zx * zx) >>> 28;
      yy = (zy * zy) >>> 28;
      t = (zx * zy) >>> 27;
      zx = clamp_q428(xx - yy + cx);
      zy = clamp_q428(t + cy);
      mag = 64'(zx * zx) + 64'(zy * zy);
      in_bound = mag < lim;
      escaped = cnt < cur_max_iter;
      if (in_bound && escaped) begin
        cnt++;
      end else begin
        break;
      end
    end
    n = cnt[15:0];
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < 30) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  task automatic push_word(input logic kind, input logic [63:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_palette(input logic [7:0] slot, input logic [31:0] color,
                              input logic [11:0] col_bits, input logic [11:0] row_bits);
    push_word(KIND_PALETTE, {color, slot, row_bits, col_bits});
    palette_shadow[slot] = color;
    palette_loaded[slot] = 1'b1;
    palette_words++;
  endtask

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                            input logic [7:0] slot_bits, input logic [31:0] color_bits,
                            input bit typed, input pixel_result_t typed_res);
    logic [15:0]   n;
    bit            escaped;
    pixel_result_t res;
    run_escape(col, row, n, escaped);
    // The palette entry this pixel reads must hold a known color first.
    if (escaped && !palette_loaded[n[7:0]]) begin
      send_palette(n[7:0], $urandom, 12'($urandom), 12'($urandom));
    end
    res.color = escaped ? palette_shadow[n[7:0]] : 32'd0;
    res.count = n;
    if (typed) res = typed_res;
    push_word(KIND_PIXEL, {color_bits, slot_bits, row, col});
    pix_expect_q.push_back(res);
    pixel_words++;
    if (!escaped) inside_count++;
    if (int'(n) > deepest) deepest = int'(n);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_X_ORIGIN:  cur_x_origin  = longint'($signed(val[31:0]));
      CFG_Y_TOP:     cur_y_top     = longint'($signed(val[31:0]));
      CFG_STEP_SIZE: cur_step      = longint'(val[30:0]);
      CFG_MAX_ITER:  cur_max_iter  = 32'(val[15:0]);
      CFG_ESC_LIMIT: cur_esc_limit = val[35:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic write_setting(input logic [31:0] x, input logic [31:0] y,
                               input logic [30:0] step, input logic [15:0] max_it,
                               input logic [35:0] esc);
    write_reg(CFG_X_ORIGIN, {4'd0, x});
    write_reg(CFG_Y_TOP, {4'd0, y});
    write_reg(CFG_STEP_SIZE, {5'd0, step});
    write_reg(CFG_MAX_ITER, {20'd0, max_it});
    write_reg(CFG_ESC_LIMIT, esc);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pix_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic vec_row_t reg_row(input logic [CFG_AW-1:0] addr,
                                       input logic [CFG_DW-1:0] val);
    vec_row_t r;
    r = '0;
    r.op = ROW_REG;
    r.addr = addr;
    r.val = val;
    return r;
  endfunction

  function automatic vec_row_t pal_row(input logic [7:0] slot, input logic [31:0] color);
    vec_row_t r;
    r = '0;
    r.op = ROW_WORD;
    r.kind = KIND_PALETTE;
    r.slot = slot;
    r.color = color;
    return r;
  endfunction

  function automatic vec_row_t pix_row(input logic [11:0] col, input logic [11:0] row);
    vec_row_t r;
    r = '0;
    r.op = ROW_WORD;
    r.kind = KIND_PIXEL;
    r.col = col;
    r.row = row;
    return r;
  endfunction

  function automatic vec_row_t typed_row(input logic [11:0] col, input logic [11:0] row,
                                         input logic [31:0] want_color,
                                         input logic [15:0] want_count);
    vec_row_t r;
    r = pix_row(col, row);
    r.op = ROW_TYPED;
    r.want_color = want_color;
    r.want_count = want_count;
    return r;
  endfunction

  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pix_expect_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pix_expect_q.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing expected", out_tdata));
      end else begin
        want = pix_expect_q.pop_front();
        if (out_tdata[31:0] !== want.color) begin
          report_mismatch($sformatf("pixel_color got %h want %h", out_tdata[31:0],
                                    want.color));
        end
        if (out_tdata[47:32] !== want.count) begin
          report_mismatch($sformatf("iteration_count got %0d want %0d", out_tdata[47:32],
                                    want.count));
        end
      end
    end
  end

  initial begin
    int            src_pct [4];
    int            sink_pct [4];
    vec_row_t      r;
    pixel_result_t typed_res;
    logic [31:0]   x, y;
    logic [30:0]   step;
    logic [15:0]   max_it;
    logic [35:0]   esc;
    logic [11:0]   col, row;
    src_pct  = '{0, 63, 0, 29};
    sink_pct = '{0, 0, 63, 29};
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= KIND_PIXEL;
    cfg_valid  <= 1'b0;
    cfg_addr   <= CFG_X_ORIGIN;
    cfg_data   <= '0;
    hold_req   <= 1'b0;
    mismatch_count = 0;
    pixel_words = 0;
    palette_words = 0;
    reg_writes = 0;
    settings = 0;
    inside_count = 0;
    deepest = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    cur_x_origin = 0;
    cur_y_top = 0;
    cur_step = 0;
    cur_max_iter = 0;
    cur_esc_limit = '0;
    foreach (palette_loaded[i]) begin
      palette_loaded[i] = 1'b0;
      palette_shadow[i] = '0;
    end

    dir_table = '{
      pal_row(8'd0, 32'hFFFF_FFFF),
      pal_row(8'd255, 32'h0000_0000),
      typed_row(12'd0, 12'd0, 32'd0, 16'd0),
      typed_row(12'd4095, 12'd4095, 32'd0, 16'd0),
      reg_row(CFG_MAX_ITER, 36'd65535),
      typed_row(12'd4095, 12'd0, 32'hFFFF_FFFF, 16'd0),
      reg_row(CFG_ESC_LIMIT, ESC_FOUR),
      reg_row(CFG_X_ORIGIN, 36'h0_E000_0000),
      reg_row(CFG_Y_TOP, 36'h0_2000_0000),
      reg_row(CFG_STEP_SIZE, 36'h0_0400_0000),
      typed_row(12'd0, 12'd0, 32'hFFFF_FFFF, 16'd0),
      typed_row(12'd16, 12'd8, 32'hFFFF_FFFF, 16'd0),
      pix_row(12'd4095, 12'd4095),
      pix_row(12'd10, 12'd8),
      reg_row(CFG_MAX_ITER, 36'd20),
      typed_row(12'd8, 12'd8, 32'd0, 16'd20),
      typed_row(12'd4, 12'd8, 32'd0, 16'd20),
      typed_row(12'd0, 12'd8, 32'hFFFF_FFFF, 16'd0),
      pix_row(12'd9, 12'd6),
      pix_row(12'd7, 12'd5),
      reg_row(CFG_X_ORIGIN, 36'h0_7FFF_FFFF),
      reg_row(CFG_Y_TOP, 36'h0_8000_0000),
      reg_row(CFG_STEP_SIZE, 36'h0_7FFF_FFFF),
      reg_row(CFG_ESC_LIMIT, 36'hF_FFFF_FFFF),
      typed_row(12'd4095, 12'd0, 32'd0, 16'd20),
      typed_row(12'd0, 12'd4095, 32'd0, 16'd20),
      pix_row(12'd2048, 12'd2048),
      reg_row(CFG_X_ORIGIN, 36'h0_8000_0000),
      reg_row(CFG_Y_TOP, 36'h0_7FFF_FFFF),
      reg_row(CFG_STEP_SIZE, 36'd0),
      reg_row(CFG_ESC_LIMIT, ESC_FOUR),
      typed_row(12'd5, 12'd5, 32'hFFFF_FFFF, 16'd0)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      r = dir_table[i];
      if (r.op == ROW_REG) begin
        if (i == 0 || dir_table[i-1].op != ROW_REG) wait_idle();
        write_reg(r.addr, r.val);
        if (i == dir_table.size() - 1 || dir_table[i+1].op != ROW_REG) begin
          cfg_valid <= 1'b0;
          settings++;
        end
      end else if (r.kind == KIND_PALETTE) begin
        send_palette(r.slot, r.color, r.col, r.row);
      end else begin
        typed_res.color = r.want_color;
        typed_res.count = r.want_count;
        send_pixel(r.col, r.row, r.slot, r.color, r.op == ROW_TYPED, typed_res);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      for (int s = 0; s < 3; s++) begin
        wait_idle();
        src_idle_pct   = src_pct[ph];
        sink_stall_pct = sink_pct[ph];
        if (s == 0 && (ph == 1 || ph == 2)) begin
          x      = $urandom;
          y      = $urandom;
          step   = 31'($urandom);
          max_it = 16'($urandom_range(0, 40));
          esc    = {4'($urandom_range(0, 15)), 32'($urandom)};
        end else begin
          x      = 32'hE000_0000 + 32'($urandom_range(0, 32'h0800_0000));
          y      = 32'h1400_0000 - 32'($urandom_range(0, 32'h0400_0000));
          step   = 31'($urandom_range(1_000_000, 4_000_000));
          max_it = (ph == 3 && s == 2) ? 16'($urandom_range(200, 600))
                                       : 16'($urandom_range(1, 64));
          esc    = ($urandom_range(99) < 80) ? ESC_FOUR
                                             : 36'($urandom_range(0, 32'h4000_0000));
        end
        write_setting(x, y, step, max_it, esc);
        // Long output stall while the input keeps streaming.
        if (ph == 0 && s == 1) hold_req <= 1'b1;
        for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
          if ($urandom_range(99) < 20) begin
            send_palette(8'($urandom), $urandom, 12'($urandom), 12'($urandom));
          end else begin
            if ($urandom_range(99) < 70) begin
              col = 12'($urandom_range(0, 255));
              row = 12'($urandom_range(0, 255));
            end else begin
              col = 12'($urandom);
              row = 12'($urandom);
            end
            send_pixel(col, row, 8'($urandom), $urandom, 1'b0, '0);
          end
        end
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Covered %0d pixel words (%0d inside the set) and %0d palette words,",
             pixel_words, inside_count, palette_words);
    $display("with %0d register writes across %0d settings; deepest count %0d.",
             reg_writes, settings, deepest);
    if (mismatch_count == 0 && pix_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mbe_pkg.sv
rtl/mbe_palette.sv
rtl/mbe_datapath.sv
rtl/mbe_ctrl.sv
rtl/mandelbrot_escape_time_pixel_core.sv
tb/mandelbrot_escape_time_pixel_core_test.sv
